/* rtl/vtx_pkg.sv */
// vtx_pkg: types, constants and arithmetic helpers for the vertex transform.
// No dependencies.
package vtx_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_GAIN  = 9949;
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;
    localparam int IN_BITS      = 112;
    localparam int OUT_BITS     = 384;

    localparam logic [2:0] CFG_MV0 = 3'd0;
    localparam logic [2:0] CFG_MV1 = 3'd1;
    localparam logic [2:0] CFG_MV2 = 3'd2;
    localparam logic [2:0] CFG_MV3 = 3'd3;
    localparam logic [2:0] CFG_PJ0 = 3'd4;
    localparam logic [2:0] CFG_PJ1 = 3'd5;
    localparam logic [2:0] CFG_PJ2 = 3'd6;
    localparam logic [2:0] CFG_PJ3 = 3'd7;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic               neg;
    } t_cord;

    function automatic logic signed [17:0] f_atan(input int i);
        logic signed [17:0] a;
        unique case (i)
            0: a = 18'sd8192;
            1: a = 18'sd4836;
            2: a = 18'sd2555;
            3: a = 18'sd1297;
            4: a = 18'sd651;
            5: a = 18'sd326;
            6: a = 18'sd163;
            7: a = 18'sd81;
            8: a = 18'sd41;
            9: a = 18'sd20;
            10: a = 18'sd10;
            11: a = 18'sd5;
            12: a = 18'sd3;
            13: a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

    function automatic t_cord f_cord(input t_cord c_in, input int first, input int n);
        t_cord c;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        c = c_in;
        for (int i = first; i < first + n; i++) begin
            dx = c.y >>> i;
            dy = c.x >>> i;
            if (c.z >= 0) begin
                c.x = c.x - dx;
                c.y = c.y + dy;
                c.z = c.z - f_atan(i);
            end else begin
                c.x = c.x + dx;
                c.y = c.y - dy;
                c.z = c.z + f_atan(i);
            end
        end
        return c;
    endfunction

    // round half up by 2^sh, then clamp to 32 bits
    function automatic logic signed [31:0] f_rnd_sat(input logic signed [63:0] v,
                                                     input int sh);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (t > 64'sd2147483647)       return 32'sh7fffffff;
        else if (t < -64'sd2147483648) return 32'sh80000000;
        else                           return t[31:0];
    endfunction

    function automatic logic signed [31:0] f_half(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = (33'(v) + 33'sd1) >>> 1;
        return t[31:0];
    endfunction

endpackage

/* rtl/vertex_transform.sv */
// vertex_transform: model-view / projection transform, halving and Y rotation.
// Depends on vtx_pkg.
//
// Usage:
//   Input stream (s_axis): one word per vertex, position and normal in Q4.12
//   plus a Y rotation angle (full turn = 65536). Output stream (m_axis): one
//   word per vertex with normal, eye and clip 4-vectors in saturated Q16.16.
//   Config port: i_cfg_we writes i_cfg_data into matrix row i_cfg_idx
//   (0..3 model-view, 4..7 projection); write only while the block is idle.
// Pipeline: seven register stages; the accepting edge of the input word
//   loads stage 1 and the output word is taken from stage 7.
// Throughput: one vertex per cycle unless the output stalls; the seven-stage
//   multiplier pipeline (model-view products, sums, projection products, sums,
//   halving, rotation products, rotation sums), CORDIC spread alongside it.
// Reset: both matrices return to identity and the pipeline empties.
// Stall: each stage holds while the next is full and stalled; empty stages
//   keep filling, so input is taken until all seven stages hold a word.
module vertex_transform
    import vtx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z, angle
    input  logic [IN_BITS-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // nrm_x..w, eye_x..w, clip_x..w
    output logic [OUT_BITS-1:0] o_m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);

    logic [63:0] r_mv [4];
    logic [63:0] r_pj [4];
    logic [7:1]  r_vld;
    logic [7:1]  rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                r_mv[r] <= 64'(64'd4096 << (16 * r));
                r_pj[r] <= 64'(64'd4096 << (16 * r));
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MV0: r_mv[0] <= i_cfg_data;
                CFG_MV1: r_mv[1] <= i_cfg_data;
                CFG_MV2: r_mv[2] <= i_cfg_data;
                CFG_MV3: r_mv[3] <= i_cfg_data;
                CFG_PJ0: r_pj[0] <= i_cfg_data;
                CFG_PJ1: r_pj[1] <= i_cfg_data;
                CFG_PJ2: r_pj[2] <= i_cfg_data;
                CFG_PJ3: r_pj[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rdy[7] = !r_vld[7] || i_m_axis_tready;
        for (int k = 6; k >= 1; k--) rdy[k] = !r_vld[k] || rdy[k+1];
    end
    assign o_s_axis_tready = rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= 7; k++) if (rdy[k]) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: model-view products, CORDIC setup and steps 0..3
    logic signed [15:0] vin [3];
    logic signed [15:0] nin [3];
    logic signed [31:0] r_pp1 [4][4];
    logic signed [31:0] r_np1 [4][3];
    t_cord              cord0;
    t_cord              r_c1, r_c2, r_c3, r_c4;
    logic signed [17:0] ang;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vin[k] = i_s_axis_tdata[16*k +: 16];
            nin[k] = i_s_axis_tdata[48 + 16*k +: 16];
        end
        ang = 18'($signed(i_s_axis_tdata[96 +: 16]));
        cord0.x = 18'(CORDIC_GAIN);
        cord0.y = '0;
        cord0.neg = 1'b0;
        cord0.z = ang;
        if (ang > 18'(QUARTER_TURN)) begin
            cord0.z = ang - 18'(HALF_TURN);
            cord0.neg = 1'b1;
        end else if (ang < -18'(QUARTER_TURN)) begin
            cord0.z = ang + 18'(HALF_TURN);
            cord0.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pp1[r][c] <= $signed(r_mv[r][16*c +: 16]) * vin[c];
                    r_np1[r][c] <= $signed(r_mv[r][16*c +: 16]) * nin[c];
                end
                r_pp1[r][3] <= 32'($signed(r_mv[r][48 +: 16])) <<< 12;
            end
            r_c1 <= f_cord(cord0, 0, 4);
        end
    end

    // stage 2: model-view sums, CORDIC steps 4..7
    logic signed [31:0] r_eye2 [4];
    logic signed [31:0] r_nrm2 [4];
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int r = 0; r < 4; r++) begin
                r_eye2[r] <= f_rnd_sat(64'(r_pp1[r][0]) + 64'(r_pp1[r][1])
                                     + 64'(r_pp1[r][2]) + 64'(r_pp1[r][3]), 8);
                r_nrm2[r] <= f_rnd_sat(64'(r_np1[r][0]) + 64'(r_np1[r][1])
                                     + 64'(r_np1[r][2]), 8);
            end
            r_c2 <= f_cord(r_c1, 4, 4);
        end
    end

    // stage 3: projection products, CORDIC steps 8..11
    logic signed [47:0] r_jp3 [4][4];
    logic signed [31:0] r_eye3 [4];
    logic signed [31:0] r_nrm3 [4];
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    r_jp3[r][c] <= $signed(r_pj[r][16*c +: 16]) * r_eye2[c];
            r_eye3 <= r_eye2;
            r_nrm3 <= r_nrm2;
            r_c3 <= f_cord(r_c2, 8, 4);
        end
    end

    // stage 4: projection sums, CORDIC finish
    logic signed [31:0] r_v4 [3][4];
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int r = 0; r < 4; r++)
                r_v4[2][r] <= f_rnd_sat(64'(r_jp3[r][0]) + 64'(r_jp3[r][1])
                                      + 64'(r_jp3[r][2]) + 64'(r_jp3[r][3]), 12);
            r_v4[0] <= r_nrm3;
            r_v4[1] <= r_eye3;
            r_c4 <= f_cord(r_c3, 12, 2);
        end
    end

    // stage 5: halving, final sine / cosine
    logic signed [31:0] r_h5 [3][4];
    logic signed [17:0] r_cos5, r_sin5;
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) r_h5[v][k] <= f_half(r_v4[v][k]);
                r_h5[v][3] <= r_v4[v][3];
            end
            r_cos5 <= r_c4.neg ? -r_c4.x : r_c4.x;
            r_sin5 <= r_c4.neg ? -r_c4.y : r_c4.y;
        end
    end

    // stage 6: rotation products
    logic signed [49:0] r_cx6 [3];
    logic signed [49:0] r_sz6 [3];
    logic signed [49:0] r_cz6 [3];
    logic signed [49:0] r_sx6 [3];
    logic signed [31:0] r_y6 [3];
    logic signed [31:0] r_w6 [3];
    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            for (int v = 0; v < 3; v++) begin
                r_cx6[v] <= r_cos5 * r_h5[v][0];
                r_sz6[v] <= r_sin5 * r_h5[v][2];
                r_cz6[v] <= r_cos5 * r_h5[v][2];
                r_sx6[v] <= r_sin5 * r_h5[v][0];
                r_y6[v]  <= r_h5[v][1];
                r_w6[v]  <= r_h5[v][3];
            end
        end
    end

    // stage 7: rotation sums, output register
    logic [OUT_BITS-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            for (int v = 0; v < 3; v++) begin
                r_out[128*v +: 32]      <= f_rnd_sat(64'(r_cx6[v]) + 64'(r_sz6[v]), 14);
                r_out[128*v + 32 +: 32] <= r_y6[v];
                r_out[128*v + 64 +: 32] <= f_rnd_sat(64'(r_cz6[v]) - 64'(r_sx6[v]), 14);
                r_out[128*v + 96 +: 32] <= r_w6[v];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[7];
    assign o_m_axis_tdata  = r_out;

endmodule

/* rtl/vtx_checker.sv */
// vtx_checker: port-level checks for vertex_transform, bound to the top level.
// Depends on vtx_pkg.
module vtx_checker
    import vtx_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic [IN_BITS-1:0]  i_s_axis_tdata,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [OUT_BITS-1:0] o_m_axis_tdata,
    input logic                i_cfg_we,
    input logic [2:0]          i_cfg_idx,
    input logic [63:0]         i_cfg_data
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    a_flow_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind vertex_transform vtx_checker u_vtx_checker (.*);
